// ===== rtl/psx_pkg.sv =====
// shared types, register indexes, encoding codes and the character class test
// for the printable string extractor; no dependencies
package psx_pkg;

  // fixed field widths of the item interfaces
  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 32;
  localparam int OUT_OFF_W = 32;
  localparam int MINLEN_W  = 7;
  localparam int MODE_W    = 3;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_TDATA_W = CHAR_W + OUT_OFF_W + LEN_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WS       = 2'd2;

  // encoding modes
  localparam logic [MODE_W-1:0] MODE_7BIT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_8BIT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_16BE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_16LE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_32BE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_32LE = 3'd5;

  // request and result kinds
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'd126;
  localparam logic [CHAR_W-1:0] CH_HIGH  = 8'd128;

  // what the unit assembler reports for the current byte
  typedef struct packed {
    logic              done;    // byte completes a unit
    logic              is_str;  // completed unit is a string character
    logic [CHAR_W-1:0] ch;      // character value of the unit
    logic [2:0]        size;    // unit size in bytes
  } unit_t;

  // string character class
  function automatic logic is_print(input logic [CHAR_W-1:0] c, input logic eight,
                                    input logic ws);
    logic ok;
    ok = (c >= CH_SPACE && c <= CH_TILDE) || (c == CH_TAB);
    if (ws && c >= CH_NL && c <= CH_CR) ok = 1'b1;
    if (eight && c >= CH_HIGH) ok = 1'b1;
    return ok;
  endfunction

endpackage

// ===== rtl/psx_cell.sv =====
// one byte cell of the hold chain: loaded from the assembler or from its
// upper neighbour when the chain drains; depends on psx_pkg
module psx_cell (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [psx_pkg::CHAR_W-1:0] wr_data,
  input  logic                      shift_en,
  input  logic [psx_pkg::CHAR_W-1:0] nb_data,
  output logic [psx_pkg::CHAR_W-1:0] q
);

  logic [psx_pkg::CHAR_W-1:0] data_r;

  // write has priority, shift moves the neighbour's byte down one cell
  always_ff @(posedge clk) begin
    if (wr_en) begin
      data_r <= wr_data;
    end else if (shift_en) begin
      data_r <= nb_data;
    end
  end

  assign q = data_r;

endmodule

// ===== rtl/psx_unit.sv =====
// code unit assembler: gathers bytes by encoding mode and classifies the
// completed unit; depends on psx_pkg
module psx_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       flush,
  input  logic [psx_pkg::CHAR_W-1:0] data_byte,
  input  logic [psx_pkg::MODE_W-1:0] mode,
  input  logic                       ws,
  output psx_pkg::unit_t             unit
);

  logic [23:0] asm_r, asm_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [psx_pkg::CHAR_W-1:0] ch;
  logic        fits;
  logic [2:0]  size;
  logic        done;

  // unit size, character and fit test per mode
  always_comb begin
    size = 3'd1;
    ch   = data_byte;
    fits = 1'b1;
    unique case (mode)
      psx_pkg::MODE_7BIT, psx_pkg::MODE_8BIT: begin
        size = 3'd1;
      end
      psx_pkg::MODE_16BE: begin
        size = 3'd2;
        fits = (asm_r[7:0] == 8'd0);
      end
      psx_pkg::MODE_16LE: begin
        size = 3'd2;
        ch   = asm_r[7:0];
        fits = (data_byte == 8'd0);
      end
      psx_pkg::MODE_32BE: begin
        size = 3'd4;
        fits = (asm_r == 24'd0);
      end
      psx_pkg::MODE_32LE: begin
        size = 3'd4;
        ch   = asm_r[23:16];
        fits = (asm_r[15:0] == 16'd0) && (data_byte == 8'd0);
      end
      default: begin
        size = 3'd1;
      end
    endcase
  end

  assign done = ({1'b0, phase_r} + 3'd1) >= size;

  assign unit.done   = done;
  assign unit.is_str = fits && psx_pkg::is_print(ch, mode == psx_pkg::MODE_8BIT, ws);
  assign unit.ch     = ch;
  assign unit.size   = size;

  // assembly state update on an accepted item
  always_comb begin
    asm_nxt   = asm_r;
    phase_nxt = phase_r;
    if (accept) begin
      if (flush || done) begin
        asm_nxt   = '0;
        phase_nxt = '0;
      end else begin
        asm_nxt   = {asm_r[15:0], data_byte};
        phase_nxt = phase_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r   <= '0;
      phase_r <= '0;
    end else begin
      asm_r   <= asm_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/printable_string_extractor_unit.sv =====
// printable string extractor top level: run tracking, hold chain of byte
// cells, result sequencer and output register; depends on psx_pkg, psx_unit, psx_cell
//
//   channel | ports            | payload
//   input   | in_t*            | tuser: req_type; tdata: data_byte
//   output  | out_t*           | tuser: item_kind; tdata: char_out, run_start_offset, run_length
//   config  | cfg_we/addr/wdata| min_len, encoding_mode, include_whitespace
//
// an item that gives no result leaves the sequencer idle; an item with results moves it
// to emit, where the hold chain shifts out one held character a cycle while the output is free
// through the single output register. reset is synchronous, active low, and clears
// all control state; the hold cells are not reset. a stalled output holds the sequencer
// and the input stays not ready until the item's results are all loaded
module printable_string_extractor_unit #(
  parameter int                HOLD_DEPTH  = 64,
  parameter int                OFFSET_BITS = 32,
  parameter longint unsigned   MAX_CHARS   = 1048575
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [psx_pkg::CHAR_W-1:0]        in_tdata,   // [7:0] data_byte
  input  logic                              in_tuser,   // [0] req_type
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [psx_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [7:0] char_out, [39:8]
                                                        // run_start_offset, [71:40] run_length
  output logic                              out_tuser,  // [0] item_kind
  // configuration writes
  input  logic                              cfg_we,
  input  logic [psx_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [psx_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
  localparam int DRAIN_W    = $clog2(HOLD_DEPTH + 1);
  localparam logic [psx_pkg::MINLEN_W-1:0] HOLD_MAX = psx_pkg::MINLEN_W'(HOLD_DEPTH);
  localparam logic [psx_pkg::LEN_W-1:0]    LEN_MAX  = '1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // configuration
  logic [psx_pkg::MINLEN_W-1:0] min_len_r;
  logic [psx_pkg::MODE_W-1:0]   mode_r;
  logic                         ws_r;
  logic [psx_pkg::MINLEN_W-1:0] min_eff;

  // run state
  state_t                       state_r, state_nxt;
  logic [OFFSET_BITS-1:0]       stream_off_r, stream_off_nxt;
  logic [OFFSET_BITS-1:0]       start_off_r, start_off_nxt;
  logic [psx_pkg::LEN_W-1:0]    run_cnt_r, run_cnt_nxt;
  logic                         released_r, released_nxt;

  // result plan for the current item
  logic [DRAIN_W-1:0]           drain_r, drain_nxt;
  logic                         emit_chr_r, emit_chr_nxt;
  logic                         emit_end_r, emit_end_nxt;
  logic [psx_pkg::CHAR_W-1:0]   chr_r, chr_nxt;
  logic [OFFSET_BITS-1:0]       plan_off_r, plan_off_nxt;
  logic [psx_pkg::LEN_W-1:0]    plan_len_r, plan_len_nxt;

  // output register
  logic                         out_vld_r, out_vld_nxt;
  logic                         out_kind_r, out_kind_nxt;
  logic [psx_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [psx_pkg::OUT_OFF_W-1:0] out_off_r, out_off_nxt;
  logic [psx_pkg::LEN_W-1:0]    out_len_r, out_len_nxt;

  // hold chain
  logic [psx_pkg::CHAR_W-1:0]   cell_q  [HOLD_DEPTH];
  logic [psx_pkg::CHAR_W-1:0]   cell_nb [HOLD_DEPTH];
  logic [HOLD_DEPTH-1:0]        wr_sel;
  logic                         cell_wr;
  logic                         shift_en;
  logic [HOLD_IDX_W-1:0]        wr_idx;

  logic                         accept;
  logic                         flush;
  logic                         slot_free;
  logic [psx_pkg::LEN_W-1:0]    cnt_inc;
  logic [OFFSET_BITS-1:0]       start_new;
  psx_pkg::unit_t               unit;

  assign accept    = in_tvalid && in_tready;
  assign flush     = (in_tuser == psx_pkg::REQ_FLUSH);
  assign in_tready = (state_r == ST_IDLE);
  assign slot_free = !out_vld_r || out_tready;

  // effective threshold, clamped to one and to the chain depth
  assign min_eff = (min_len_r == '0) ? psx_pkg::MINLEN_W'(1) :
                   ((min_len_r > HOLD_MAX) ? HOLD_MAX : min_len_r);

  // held characters to release for a run of cnt units
  function automatic logic [DRAIN_W-1:0] drain_len(input logic [psx_pkg::LEN_W-1:0] cnt);
    logic [DRAIN_W-1:0] lim;
    lim = (cnt < psx_pkg::LEN_W'(HOLD_DEPTH)) ? cnt[DRAIN_W-1:0] : DRAIN_W'(HOLD_DEPTH);
    if (64'(lim) > MAX_CHARS) lim = DRAIN_W'(MAX_CHARS);
    return lim;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= psx_pkg::MINLEN_W'(4);
      mode_r    <= psx_pkg::MODE_7BIT;
      ws_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        psx_pkg::CFG_MIN_LEN:  min_len_r <= cfg_wdata;
        psx_pkg::CFG_ENC_MODE: mode_r    <= cfg_wdata[psx_pkg::MODE_W-1:0];
        psx_pkg::CFG_WS:       ws_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // unit assembly and classification
  psx_unit u_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .flush     (flush),
    .data_byte (in_tdata),
    .mode      (mode_r),
    .ws        (ws_r),
    .unit      (unit)
  );

  // hold chain of byte cells, drained towards cell zero
  assign wr_idx = run_cnt_r[HOLD_IDX_W-1:0];

  for (genvar i = 0; i < HOLD_DEPTH; i++) begin : g_cell
    if (i == HOLD_DEPTH - 1) begin : g_tail
      assign cell_nb[i] = '0;
    end else begin : g_body
      assign cell_nb[i] = cell_q[i+1];
    end
    assign wr_sel[i] = cell_wr && (wr_idx == HOLD_IDX_W'(i));
    psx_cell u_cell (
      .clk      (clk),
      .wr_en    (wr_sel[i]),
      .wr_data  (unit.ch),
      .shift_en (shift_en),
      .nb_data  (cell_nb[i]),
      .q        (cell_q[i])
    );
  end

  assign cnt_inc   = (run_cnt_r == LEN_MAX) ? run_cnt_r : run_cnt_r + 1'b1;
  assign start_new = (run_cnt_r == '0) ? stream_off_r : start_off_r;

  // run tracking on accept, result sequencing while emitting
  always_comb begin
    state_nxt      = state_r;
    stream_off_nxt = stream_off_r;
    start_off_nxt  = start_off_r;
    run_cnt_nxt    = run_cnt_r;
    released_nxt   = released_r;
    drain_nxt      = drain_r;
    emit_chr_nxt   = emit_chr_r;
    emit_end_nxt   = emit_end_r;
    chr_nxt        = chr_r;
    plan_off_nxt   = plan_off_r;
    plan_len_nxt   = plan_len_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_char_nxt   = out_char_r;
    out_off_nxt    = out_off_r;
    out_len_nxt    = out_len_r;
    cell_wr        = 1'b0;
    shift_en       = 1'b0;

    if (accept) begin
      drain_nxt    = '0;
      emit_chr_nxt = 1'b0;
      emit_end_nxt = 1'b0;
      plan_off_nxt = start_off_r;
      plan_len_nxt = run_cnt_r;
      if (!flush && unit.done) begin
        stream_off_nxt = stream_off_r + OFFSET_BITS'(unit.size);
      end
      if (!flush && unit.done && unit.is_str) begin
        // string character: extend the run
        start_off_nxt = start_new;
        plan_off_nxt  = start_new;
        cell_wr       = !released_r && (run_cnt_r < psx_pkg::LEN_W'(HOLD_DEPTH));
        run_cnt_nxt   = cnt_inc;
        chr_nxt       = unit.ch;
        if (released_r) begin
          emit_chr_nxt = (64'(run_cnt_r) < MAX_CHARS);
        end else if (cnt_inc >= psx_pkg::LEN_W'(min_eff)) begin
          released_nxt = 1'b1;
          drain_nxt    = drain_len(cnt_inc);
        end
      end else if (flush || unit.done) begin
        // run ends: release a qualifying run, then its terminator
        if (released_r) begin
          emit_end_nxt = 1'b1;
        end else if (run_cnt_r != '0 && run_cnt_r >= psx_pkg::LEN_W'(min_eff)) begin
          drain_nxt    = drain_len(run_cnt_r);
          emit_end_nxt = 1'b1;
        end
        run_cnt_nxt  = '0;
        released_nxt = 1'b0;
        if (flush) begin
          stream_off_nxt = '0;
          start_off_nxt  = '0;
        end
      end
      if (drain_nxt != '0 || emit_chr_nxt || emit_end_nxt) begin
        state_nxt = ST_EMIT;
      end
    end else if (state_r == ST_EMIT && slot_free) begin
      // load the next result into the output register
      out_vld_nxt = 1'b1;
      out_off_nxt = psx_pkg::OUT_OFF_W'(plan_off_r);
      priority if (drain_r != '0) begin
        out_kind_nxt = psx_pkg::KIND_CHAR;
        out_char_nxt = cell_q[0];
        out_len_nxt  = '0;
        shift_en     = 1'b1;
        drain_nxt    = drain_r - 1'b1;
      end else if (emit_chr_r) begin
        out_kind_nxt = psx_pkg::KIND_CHAR;
        out_char_nxt = chr_r;
        out_len_nxt  = '0;
        emit_chr_nxt = 1'b0;
      end else begin
        out_kind_nxt = psx_pkg::KIND_END;
        out_char_nxt = '0;
        out_len_nxt  = plan_len_r;
        emit_end_nxt = 1'b0;
      end
      if (drain_nxt == '0 && !emit_chr_nxt && !emit_end_nxt) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      stream_off_r <= '0;
      start_off_r  <= '0;
      run_cnt_r    <= '0;
      released_r   <= 1'b0;
      drain_r      <= '0;
      emit_chr_r   <= 1'b0;
      emit_end_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      stream_off_r <= stream_off_nxt;
      start_off_r  <= start_off_nxt;
      run_cnt_r    <= run_cnt_nxt;
      released_r   <= released_nxt;
      drain_r      <= drain_nxt;
      emit_chr_r   <= emit_chr_nxt;
      emit_end_r   <= emit_end_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chr_r      <= chr_nxt;
    plan_off_r <= plan_off_nxt;
    plan_len_r <= plan_len_nxt;
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_off_r  <= out_off_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_len_r, out_off_r, out_char_r};

`ifndef SYNTHESIS
  // a released run always has at least one unit
  a_released_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    released_r |-> (run_cnt_r != '0))
    else $error("released run with zero length");

  // the sequencer never sits in emit with nothing left to send
  a_emit_plan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (drain_r != '0 || emit_chr_r || emit_end_r))
    else $error("emit state with empty plan");

  // the drain count never exceeds the chain depth
  a_drain_max: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r <= DRAIN_W'(HOLD_DEPTH))
    else $error("drain count beyond hold depth");

  // a flush restarts the byte offsets
  a_flush_off: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && flush) |=> (stream_off_r == '0 && start_off_r == '0 && run_cnt_r == '0))
    else $error("flush did not clear offsets");
`endif

endmodule

// ===== test/tb_printable_string_extractor_unit.sv =====
// self-checking testbench for printable_string_extractor_unit: directed and random byte
// streams through a local string predictor, results checked item by item in order
// depends on psx_pkg and the extractor rtl only
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psx_pkg::*;

  localparam int              HOLD_CELLS   = 64;
  localparam longint unsigned RUN_CHAR_CAP = 1048575;
  localparam int              SETTLE_TAIL  = 4;
  localparam int              STALL_CYCLES = 400;
  localparam int              REPORT_MAX   = 10;

  // one result item as the predictor sees it
  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] ch;
    logic [31:0]       off;
    logic [31:0]       len;
  } str_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [CHAR_W-1:0]      in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  printable_string_extractor_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // predictor copy of the registers and run state
  logic [MINLEN_W-1:0] min_len_r = 7'd4;
  logic [MODE_W-1:0]   mode_r = MODE_7BIT;
  logic                ws_r = 1'b0;
  logic [23:0]         asm_bytes = '0;
  logic [1:0]          phase = '0;
  logic [31:0]         byte_pos = '0;
  logic [31:0]         run_start = '0;
  logic [31:0]         run_len = '0;
  logic                run_shown = 1'b0;
  logic [CHAR_W-1:0]   held [HOLD_CELLS];

  str_item_t due_items[$];
  int        errors = 0;
  int        items_sent = 0;
  int        send_gap_pct = 33;
  int        sink_stall_pct = 50;
  int        hold_serial = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  // encoding modes 6 and 7 behave as the 7-bit byte mode
  function automatic logic [MODE_W-1:0] unit_mode();
    return (mode_r > MODE_32LE) ? MODE_7BIT : mode_r;
  endfunction

  function automatic int unit_bytes();
    logic [MODE_W-1:0] m;
    m = unit_mode();
    return (m <= MODE_8BIT) ? 1 : ((m <= MODE_16LE) ? 2 : 4);
  endfunction

  // effective threshold, clamped to the hold depth
  function automatic int min_run();
    int m;
    m = int'(min_len_r);
    if (m < 1) m = 1;
    if (m > HOLD_CELLS) m = HOLD_CELLS;
    return m;
  endfunction

  function automatic logic char_ok(input logic [CHAR_W-1:0] c, input logic eight);
    if (c >= 8'd32 && c <= 8'd126) return 1'b1;
    if (c == CH_TAB) return 1'b1;
    if (ws_r && c >= 8'd10 && c <= 8'd13) return 1'b1;
    if (eight && c >= 8'd128) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_due(input logic kind, input logic [CHAR_W-1:0] ch,
                                   input logic [31:0] len);
    str_item_t e;
    e.kind = kind;
    e.ch   = ch;
    e.off  = run_start;
    e.len  = len;
    due_items.push_back(e);
  endfunction

  // emit the held characters of the current run
  function automatic void release_held();
    int lim;
    lim = (run_len < HOLD_CELLS) ? int'(run_len) : HOLD_CELLS;
    for (int k = 0; k < lim && k < RUN_CHAR_CAP; k++) push_due(KIND_CHAR, held[k], 32'd0);
    run_shown = 1'b1;
  endfunction

  function automatic void close_run();
    if (!run_shown && run_len > 0 && run_len >= min_run()) release_held();
    if (run_shown) push_due(KIND_END, 8'd0, run_len);
    run_len   = '0;
    run_shown = 1'b0;
  endfunction

  // string predictor: one accepted item in, expected result items queued
  function automatic void extract_strings(input logic req, input logic [CHAR_W-1:0] b);
    logic [MODE_W-1:0] m;
    int                size;
    logic [CHAR_W-1:0] ch;
    logic              fits;
    logic [31:0]       unit_pos;
    logic [31:0]       idx;
    if (req == REQ_FLUSH) begin
      close_run();
      asm_bytes = '0;
      phase     = '0;
      byte_pos  = '0;
      run_start = '0;
      return;
    end
    m = unit_mode();
    size = unit_bytes();
    if (int'(phase) + 1 < size) begin
      asm_bytes = {asm_bytes[15:0], b};
      phase = phase + 2'd1;
      return;
    end
    case (m)
      MODE_16BE: begin
        ch = b;
        fits = (asm_bytes[7:0] == 8'd0);
      end
      MODE_16LE: begin
        ch = asm_bytes[7:0];
        fits = (b == 8'd0);
      end
      MODE_32BE: begin
        ch = b;
        fits = (asm_bytes == 24'd0);
      end
      MODE_32LE: begin
        ch = asm_bytes[23:16];
        fits = (asm_bytes[15:0] == 16'd0) && (b == 8'd0);
      end
      default: begin
        ch = b;
        fits = 1'b1;
      end
    endcase
    asm_bytes = '0;
    phase     = '0;
    unit_pos  = byte_pos;
    byte_pos  = byte_pos + size;
    if (fits && char_ok(ch, m == MODE_8BIT)) begin
      if (run_len == 0) run_start = unit_pos;
      idx = run_len;
      if (!run_shown && idx < HOLD_CELLS) held[idx] = ch;
      if (run_len != 32'hFFFF_FFFF) run_len = run_len + 32'd1;
      if (run_shown) begin
        if (idx < RUN_CHAR_CAP) push_due(KIND_CHAR, ch, 32'd0);
      end else if (run_len >= min_run()) begin
        release_held();
      end
    end else begin
      close_run();
    end
  endfunction

  // result side: random stalls, long hold-off on request, in-order checking
  always @(posedge clk) begin
    str_item_t got;
    str_item_t exp;
    if (out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[7:0], out_tdata[39:8], out_tdata[71:40]};
      if (due_items.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected item: kind %0d char %02h offset %0d length %0d",
                   got.kind, got.ch, got.off, got.len);
      end else begin
        exp = due_items.pop_front();
        if (got !== exp) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("mismatch: expected kind %0d char %02h offset %0d length %0d, %s",
                     exp.kind, exp.ch, exp.off, exp.len,
                     $sformatf("got kind %0d char %02h offset %0d length %0d",
                               got.kind, got.ch, got.off, got.len));
        end
      end
    end
    if (hold_serial != hold_seen) begin
      hold_seen = hold_serial;
      hold_left = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // offer one item, wait for its handshake, then predict its results
  task automatic send_item(input logic req, input logic [CHAR_W-1:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    extract_strings(req, b);
    items_sent++;
  endtask

  // one code unit in the current encoding
  task automatic send_unit(input logic [CHAR_W-1:0] c);
    case (unit_mode())
      MODE_16BE: begin
        send_item(REQ_DATA, 8'd0);
        send_item(REQ_DATA, c);
      end
      MODE_16LE: begin
        send_item(REQ_DATA, c);
        send_item(REQ_DATA, 8'd0);
      end
      MODE_32BE: begin
        repeat (3) send_item(REQ_DATA, 8'd0);
        send_item(REQ_DATA, c);
      end
      MODE_32LE: begin
        send_item(REQ_DATA, c);
        repeat (3) send_item(REQ_DATA, 8'd0);
      end
      default: send_item(REQ_DATA, c);
    endcase
  endtask

  // stop offering and wait until every expected item has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (due_items.size() != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    settle();
    cfg_addr  <= idx;
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_LEN:  min_len_r = value[MINLEN_W-1:0];
      CFG_ENC_MODE: mode_r = value[MODE_W-1:0];
      CFG_WS:       ws_r = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // characters that a run may hold in the current setting
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (unit_mode() == MODE_8BIT && r < 20) return 8'($urandom_range(128, 255));
    if (ws_r && r >= 20 && r < 30) return 8'($urandom_range(10, 13));
    if (r >= 30 && r < 35) return CH_TAB;
    return 8'($urandom_range(32, 126));
  endfunction

  // a unit value that never belongs to a string
  function automatic logic [CHAR_W-1:0] pick_stop();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd127;
      2: return 8'($urandom_range(14, 31));
      default: return 8'($urandom_range(0, 8));
    endcase
  endfunction

  task automatic random_setup();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) write_reg(CFG_MIN_LEN, 7'd0);
    else if (r < 20) write_reg(CFG_MIN_LEN, 7'($urandom_range(7, 127)));
    else write_reg(CFG_MIN_LEN, 7'($urandom_range(1, 6)));
    write_reg(CFG_ENC_MODE, 7'($urandom_range(0, 7)));
    write_reg(CFG_WS, 7'($urandom_range(0, 1)));
  endtask

  // byte classes under the reset setting: 7-bit, threshold 4, no extra whitespace
  task automatic test_byte_classes();
    send_item(REQ_DATA, "A");
    send_item(REQ_DATA, CH_TAB);
    send_item(REQ_DATA, CH_TILDE);
    send_item(REQ_DATA, CH_SPACE);
    send_item(REQ_DATA, 8'd31);
    send_item(REQ_DATA, 8'd127);
    send_item(REQ_DATA, 8'd0);
    send_item(REQ_DATA, "x");
    // short run dropped by end of stream, data ignored
    send_item(REQ_FLUSH, 8'hFF);
  endtask

  // high bytes and extra whitespace, then 16-bit big endian units
  task automatic test_wide_chars();
    write_reg(CFG_MIN_LEN, 7'd1);
    write_reg(CFG_ENC_MODE, CFG_W'(MODE_8BIT));
    write_reg(CFG_WS, 7'd1);
    send_item(REQ_DATA, 8'hFF);
    send_item(REQ_DATA, CH_HIGH);
    send_item(REQ_DATA, CH_CR);
    send_item(REQ_DATA, CH_NL);
    send_item(REQ_DATA, 8'd127);
    write_reg(CFG_WS, 7'd0);
    write_reg(CFG_ENC_MODE, CFG_W'(MODE_16BE));
    send_unit("Z");
    // high byte set: unit is above 255 and ends the run
    send_item(REQ_DATA, 8'd1);
    send_item(REQ_DATA, "Z");
  endtask

  // switch from 32-bit to 16-bit units with two bytes already assembled
  task automatic test_unit_resize();
    write_reg(CFG_ENC_MODE, CFG_W'(MODE_32BE));
    send_item(REQ_DATA, 8'd0);
    send_item(REQ_DATA, "k");
    write_reg(CFG_ENC_MODE, CFG_W'(MODE_16LE));
    send_item(REQ_DATA, 8'd0);
    send_item(REQ_FLUSH, 8'd0);
  endtask

  // lower the threshold while a run is held back
  task automatic test_threshold_change();
    write_reg(CFG_ENC_MODE, CFG_W'(MODE_7BIT));
    write_reg(CFG_MIN_LEN, 7'd64);
    send_item(REQ_DATA, "a");
    send_item(REQ_DATA, "b");
    send_item(REQ_DATA, "c");
    write_reg(CFG_MIN_LEN, 7'd2);
    send_item(REQ_DATA, "d");
    send_item(REQ_FLUSH, 8'd0);
    write_reg(CFG_MIN_LEN, 7'd127);
    write_reg(CFG_ENC_MODE, 7'd7);
  endtask

  // mostly well-formed runs with random content, plus noise and flushes
  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int count);
    int first;
    int next_cfg;
    int r;
    int n;
    int left;
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    first    = items_sent;
    next_cfg = items_sent;
    while (items_sent - first < count) begin
      if (items_sent >= next_cfg) begin
        random_setup();
        next_cfg = items_sent + $urandom_range(10, 20);
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 6);
        // keep the run inside the remaining item budget
        left = (count - (items_sent - first)) / unit_bytes();
        if (n > left - 1) n = (left > 1) ? left - 1 : 0;
        repeat (n) send_unit(pick_char());
        send_unit(pick_stop());
      end else if (r < 80) begin
        repeat (unit_bytes()) send_item(REQ_DATA, 8'($urandom));
      end else if (r < 90) begin
        send_item(REQ_FLUSH, 8'($urandom));
      end else begin
        // stray byte that shifts the unit alignment
        send_item(REQ_DATA, 8'($urandom));
      end
    end
  endtask

  // long receiver hold-off during the release of a held run, sender keeps offering
  task automatic test_backpressure();
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    write_reg(CFG_ENC_MODE, CFG_W'(MODE_7BIT));
    write_reg(CFG_WS, 7'd0);
    write_reg(CFG_MIN_LEN, 7'd16);
    hold_serial++;
    for (int k = 0; k < 20; k++) send_item(REQ_DATA, 8'(65 + k % 26));
    send_item(REQ_DATA, 8'd0);
    send_item(REQ_FLUSH, 8'd0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_byte_classes();
    test_wide_chars();
    test_unit_resize();
    test_threshold_change();
    test_random_traffic(33, 50, 20);
    test_random_traffic(50, 33, 20);
    test_random_traffic(0, 0, 20);
    test_backpressure();
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && due_items.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/psx_pkg.sv
rtl/psx_cell.sv
rtl/psx_unit.sv
rtl/printable_string_extractor_unit.sv
test/tb_printable_string_extractor_unit.sv
